// ===== sv/camera_vector_normalize_rotate_assert.svh =====
// Assertion macros for the vector rotator.
`ifndef CAMERA_VECTOR_NORMALIZE_ROTATE_ASSERT_SVH
`define CAMERA_VECTOR_NORMALIZE_ROTATE_ASSERT_SVH
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
`define CVNR_ASSERT_IMPLIES(lbl, rst_n, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("check failed");
`define CVNR_ASSERT_NEXT(lbl, rst_n, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("check failed");
`endif

// ===== sv/cvnr_pkg.sv =====
package cvnr_pkg;
    localparam logic [1:0] REG_EAST  = 2'd0;
    localparam logic [1:0] REG_NORTH = 2'd1;
    localparam logic [1:0] REG_UP    = 2'd2;
    localparam int SUM_W = 32;
    localparam int ROOT_W = 16;
    typedef logic signed [15:0] t_coef;
endpackage

// ===== sv/camera_vector_normalize_rotate.sv =====
// camera_vector_normalize_rotate
// Input stream s_axis: tdata = {cam_z, cam_y, cam_x} (x lowest), tlast = last_vector.
// Output stream m_axis: tdata = {up, north, east}, tuser = zero_length, tlast = last_out.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 east, 1 north,
// 2 up row) and i_cfg_data (three Q2.14 coefficients, column one lowest).
// Write rows only while no words are in flight.
// Throughput: one word per cycle while m_axis is not stalled. The pipeline has
// NST = 3 + 16 (square root, one result bit per stage) + DIV_W (divide, one
// quotient bit per stage) + 3 (multiply, sum and shift, saturate) register
// stages; a word accepted on s_axis is offered on m_axis from the last of them.
// Depth is set by the bit-serial root and divide stages.
// A stalled receiver freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits and rows; payload registers are not reset.
module camera_vector_normalize_rotate
    import cvnr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cam_x, cam_y, cam_z
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // east, north, up
    output logic        m_axis_tuser,   // zero_length
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    localparam int DIV_W = 16 + COEF_FRAC_BITS;     // dividend width
    localparam int ROOT_END = 3 + ROOT_W;
    localparam int DIV_END = ROOT_END + DIV_W;
    localparam int NST = DIV_END + 3;               // total stages
    localparam int PW = COEF_FRAC_BITS + 2;         // unit magnitude width
    localparam int PRW = PW + 17;                   // product width
    localparam int ACW = PRW + 2;
    localparam logic signed [ACW-1:0] SAT_HI = ACW'(32767);
    localparam logic signed [ACW-1:0] SAT_LO = ACW'(-32768);

    function automatic logic [DIV_W+1:0] div_step(logic [DIV_W:0] rem, logic din,
                                                  logic [ROOT_W-1:0] d);
        logic [DIV_W:0] rm;
        rm = {rem[DIV_W-1:0], din};
        if (rm >= (DIV_W+1)'(d)) begin
            return {rm - (DIV_W+1)'(d), 1'b1};
        end
        return {rm, 1'b0};
    endfunction

    function automatic logic signed [PW:0] signed_unit(logic [PW-1:0] mag, logic neg);
        logic signed [PW:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    logic [47:0] r_row [3];
    logic        en;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0; r_row[1] <= '0; r_row[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_EAST:  r_row[0] <= i_cfg_data;
                REG_NORTH: r_row[1] <= i_cfg_data;
                REG_UP:    r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage payload
    logic [NST-1:0]          r_v;
    logic [15:0]             r_m   [DIV_END-1][3];   // component magnitudes
    logic [2:0]              r_neg [DIV_END];
    logic                    r_last[NST];
    logic [SUM_W-1:0]        r_s   [1:ROOT_END-1];   // remaining radicand
    logic [SUM_W-1:0]        r_sq;                   // x^2 + y^2
    logic [ROOT_W-1:0]       r_q   [2:DIV_END-1];    // root
    logic [DIV_W:0]          r_rem [DIV_W][3];
    logic [DIV_W-1:0]        r_quo [DIV_W][3];
    logic signed [PRW-1:0]   r_pr  [3][3];
    logic signed [ACW-1:0]   r_sum [3];
    logic [15:0]             r_out [3];
    logic [2:0]              r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[NST-2:0], s_axis_tvalid};
    end

    logic signed [15:0] cin [3];
    assign cin[0] = s_axis_tdata[15:0];
    assign cin[1] = s_axis_tdata[31:16];
    assign cin[2] = s_axis_tdata[47:32];

    always_ff @(posedge i_clk) begin
        logic [SUM_W-1:0]      t;
        logic [DIV_W-1:0]      dd;
        logic [DIV_W+1:0]      st;
        logic signed [PW:0]    pv [3];
        logic signed [ACW-1:0] s;
        logic signed [ACW-1:0] nv;
        if (en) begin
            // stage 0: magnitudes
            for (int c = 0; c < 3; c++) begin
                r_m[0][c] <= cin[c][15] ? 16'(-cin[c]) : cin[c];
                r_neg[0][c] <= cin[c][15];
            end
            r_last[0] <= s_axis_tlast;
            for (int k = 1; k < DIV_END - 1; k++) r_m[k] <= r_m[k-1];
            for (int k = 1; k < DIV_END; k++) r_neg[k] <= r_neg[k-1];
            for (int k = 1; k < NST; k++) r_last[k] <= r_last[k-1];
            // stage 1: squares
            r_sq <= SUM_W'(r_m[0][0]) * SUM_W'(r_m[0][0])
                  + SUM_W'(r_m[0][1]) * SUM_W'(r_m[0][1]);
            r_s[1] <= SUM_W'(r_m[0][2]) * SUM_W'(r_m[0][2]);
            // stage 2: sum (max 3*2^30 fits 32 bits)
            r_s[2] <= r_s[1] + r_sq;
            r_q[2] <= '0;
            // root stages: one bit each
            for (int b = 0; b < ROOT_W; b++) begin
                t = SUM_W'({r_q[2+b], 2'b01}) << (2 * (ROOT_W - 1 - b));
                if (r_s[2+b] >= t) begin
                    r_s[3+b] <= r_s[2+b] - t;
                    r_q[3+b] <= {r_q[2+b][ROOT_W-2:0], 1'b1};
                end else begin
                    r_s[3+b] <= r_s[2+b];
                    r_q[3+b] <= {r_q[2+b][ROOT_W-2:0], 1'b0};
                end
            end
            for (int k = ROOT_END; k < DIV_END; k++) r_q[k] <= r_q[k-1];
            // divide stages: restoring, one bit each (stage ROOT_END starts)
            for (int c = 0; c < 3; c++) begin
                dd = {r_m[ROOT_END-1][c], {COEF_FRAC_BITS{1'b0}}};
                st = div_step('0, dd[DIV_W-1], r_q[ROOT_END-1]);
                r_rem[0][c] <= st[DIV_W+1:1];
                r_quo[0][c] <= DIV_W'(st[0]);
            end
            for (int b = 1; b < DIV_W; b++) begin
                for (int c = 0; c < 3; c++) begin
                    dd = {r_m[ROOT_END-1+b][c], {COEF_FRAC_BITS{1'b0}}};
                    st = div_step(r_rem[b-1][c], dd[DIV_W-1-b], r_q[ROOT_END-1+b]);
                    r_rem[b][c] <= st[DIV_W+1:1];
                    r_quo[b][c] <= {r_quo[b-1][c][DIV_W-2:0], st[0]};
                end
            end
            // multiply stage: p = (-u_z, u_x, -u_y)
            pv[0] = signed_unit(r_quo[DIV_W-1][2][PW-1:0], !r_neg[DIV_END-1][2]);
            pv[1] = signed_unit(r_quo[DIV_W-1][0][PW-1:0], r_neg[DIV_END-1][0]);
            pv[2] = signed_unit(r_quo[DIV_W-1][1][PW-1:0], !r_neg[DIV_END-1][1]);
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[r][j] <= t_coef'(r_row[r][16*j +: 16]) * pv[j];
                end
            end
            r_zero[0] <= (r_q[DIV_END-1] == '0);
            // sum and floor shift
            for (int r = 0; r < 3; r++) begin
                s = ACW'(r_pr[r][0]) + ACW'(r_pr[r][1]) + ACW'(r_pr[r][2]);
                r_sum[r] <= s >>> COEF_FRAC_BITS;
            end
            r_zero[1] <= r_zero[0];
            // negate east and up, saturate
            for (int r = 0; r < 3; r++) begin
                nv = (r == 1) ? r_sum[r] : -r_sum[r];
                if (r_zero[1]) r_out[r] <= '0;
                else if (nv > SAT_HI) r_out[r] <= 16'h7fff;
                else if (nv < SAT_LO) r_out[r] <= 16'h8000;
                else r_out[r] <= nv[15:0];
            end
            r_zero[2] <= r_zero[1];
        end
    end

    assign m_axis_tvalid = r_v[NST-1];
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_zero[2];
    assign m_axis_tlast  = r_last[NST-1];

    `include "camera_vector_normalize_rotate_assert.svh"
    `CVNR_ASSERT_NEXT(a_hold, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CVNR_ASSERT_NEXT(a_stable, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CVNR_ASSERT_IMPLIES(a_zero, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
    import cvnr_pkg::*;
();

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int FRAC = 14;
    localparam int DRAIN = 100;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } t_vec;

    typedef struct {
        logic [15:0] east;
        logic [15:0] north;
        logic [15:0] up;
        logic        zero_len;
        logic        last;
    } t_world;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // cam_x, cam_y, cam_z
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // east, north, up
    logic        m_axis_tuser;       // zero_length
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    camera_vector_normalize_rotate dut (.*);

    always #5 i_clk = ~i_clk;

    t_vec       vec_q[$];
    t_world     world_q[$];
    logic [47:0] rows[3];
    int         errs = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    bit         send_burst = 0;
    bit         recv_burst = 0;

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_of(longint c, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? -c : c;
        q = (mag << FRAC) / len;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint row_dot(logic [47:0] r, longint p0, longint p1, longint p2);
        longint acc;
        acc = longint'($signed(r[15:0])) * p0 + longint'($signed(r[31:16])) * p1
            + longint'($signed(r[47:32])) * p2;
        return acc >>> FRAC;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_world rotate_vec(t_vec v);
        t_world w;
        longint x, y, z, p0, p1, p2;
        longint unsigned len;
        x = longint'(v.x);
        y = longint'(v.y);
        z = longint'(v.z);
        w.last = v.last;
        len = int_sqrt(longint'(x * x + y * y + z * z));
        if (len == 0) begin
            w.east = '0;
            w.north = '0;
            w.up = '0;
            w.zero_len = 1'b1;
            return w;
        end
        p0 = -unit_of(z, len);
        p1 = unit_of(x, len);
        p2 = -unit_of(y, len);
        w.east = clamp16(-row_dot(rows[0], p0, p1, p2));
        w.north = clamp16(row_dot(rows[1], p0, p1, p2));
        w.up = clamp16(-row_dot(rows[2], p0, p1, p2));
        w.zero_len = 1'b0;
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic nv;
        t_vec v;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                v.x = s_axis_tdata[15:0];
                v.y = s_axis_tdata[31:16];
                v.z = s_axis_tdata[47:32];
                v.last = s_axis_tlast;
                world_q.push_back(rotate_vec(v));
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (vec_q.size() > 0) begin
                    v = vec_q.pop_front();
                    s_axis_tdata <= {v.z, v.y, v.x};
                    s_axis_tlast <= v.last;
                    nv = 1'b1;
                    if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 15);
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_world w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (world_q.size() == 0) begin
                    $error("unexpected word %h", m_axis_tdata);
                    errs++;
                end else begin
                    w = world_q.pop_front();
                    if (m_axis_tdata[15:0] !== w.east) begin
                        $error("east exp %h got %h", w.east, m_axis_tdata[15:0]);
                        errs++;
                    end
                    if (m_axis_tdata[31:16] !== w.north) begin
                        $error("north exp %h got %h", w.north, m_axis_tdata[31:16]);
                        errs++;
                    end
                    if (m_axis_tdata[47:32] !== w.up) begin
                        $error("up exp %h got %h", w.up, m_axis_tdata[47:32]);
                        errs++;
                    end
                    if (m_axis_tuser !== w.zero_len) begin
                        $error("zero_length exp %b got %b", w.zero_len, m_axis_tuser);
                        errs++;
                    end
                    if (m_axis_tlast !== w.last) begin
                        $error("last_out exp %b got %b", w.last, m_axis_tlast);
                        errs++;
                    end
                end
                if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_row(logic [1:0] idx, logic [47:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx != REG_NONE) rows[idx] = data;
    endtask

    task automatic wait_idle();
        while (vec_q.size() != 0 || world_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic add_vec(int x, int y, int z, bit last);
        t_vec v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        v.last = last;
        vec_q.push_back(v);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 4) - 2);
            1: return 16'($urandom_range(0, 255) - 128);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_row();
        logic [47:0] r;
        r = 48'({$urandom, $urandom});
        if ($urandom_range(0, 1))
            for (int i = 0; i < 3; i++)
                r[16*i +: 16] = 16'($urandom_range(0, 32768) - 16384);
        return r;
    endfunction

    task automatic random_batch(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0)
                add_vec(0, 0, 0, $urandom_range(0, 1));
            else if (k == 1)
                add_vec(($urandom_range(0, 2) == 0) ? rand_comp() : 0,
                        ($urandom_range(0, 2) == 1) ? rand_comp() : 0,
                        ($urandom_range(0, 2) == 2) ? rand_comp() : 0,
                        $urandom_range(0, 1));
            else
                add_vec(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic [47:0] ident_e, ident_n, ident_u;
        rows[0] = '0;
        rows[1] = '0;
        rows[2] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset rows give zero outputs
        add_vec(0, 0, 0, 1);
        add_vec(1, 0, 0, 0);
        add_vec(-32768, -32768, -32768, 1);
        random_batch(30);
        wait_idle();

        ident_e = {16'sh0000, 16'sh0000, 16'sh4000};
        ident_n = {16'sh0000, 16'sh4000, 16'sh0000};
        ident_u = {16'sh4000, 16'sh0000, 16'sh0000};
        write_row(REG_EAST, ident_e);
        write_row(REG_NORTH, ident_n);
        write_row(REG_UP, ident_u);
        write_row(REG_NONE, 48'hFFFF_FFFF_FFFF);
        add_vec(0, 0, 0, 0);
        add_vec(32767, 0, 0, 0);
        add_vec(-32768, 0, 0, 1);
        add_vec(0, 32767, 0, 0);
        add_vec(0, -32768, 0, 0);
        add_vec(0, 0, 32767, 0);
        add_vec(0, 0, -32768, 1);
        add_vec(-1, -1, -1, 0);
        add_vec(1, 1, 1, 0);
        add_vec(32767, 32767, 32767, 0);
        add_vec(-32768, 32767, -32768, 1);
        add_vec(3, -4, 12, 0);
        random_batch(300);
        wait_idle();

        // saturation extremes
        write_row(REG_EAST, 48'h8000_8000_8000);
        write_row(REG_NORTH, 48'h7FFF_7FFF_7FFF);
        write_row(REG_UP, 48'h7FFF_8000_7FFF);
        add_vec(-32768, 32767, 32767, 0);
        add_vec(32767, -32768, -32768, 1);
        add_vec(100, -100, 100, 0);
        random_batch(300);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_row(REG_EAST, rand_row());
            write_row(REG_NORTH, rand_row());
            write_row(REG_UP, rand_row());
            random_batch(310);
            wait_idle();
        end

        if (world_q.size() != 0) begin
            $error("%0d words never arrived", world_q.size());
            errs++;
        end
        if (errs == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
